// ===== sv/srvramp_pkg.sv =====
`timescale 1ns / 1ps

package srvramp_pkg;

  localparam int WIDTH_BITS     = 12;
  localparam int MAX_RAMP_STEPS = 64;
  localparam int CNT_W          = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 12;
  localparam int DIV_ITERS      = WIDTH_BITS;
  localparam int DCNT_W         = $clog2(DIV_ITERS + 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVED_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS     = 2'd2;

  localparam logic [CNT_W-1:0] RAMP_STEPS_RESET = 7'd10;

  // operation codes
  localparam logic OP_ACTIVATE = 1'b0;
  localparam logic OP_ROUTE    = 1'b1;

  // route codes
  localparam logic ROUTE_STRAIGHT = 1'b0;
  localparam logic ROUTE_CURVED   = 1'b1;

  typedef struct packed {
    logic operation;
    logic desired_route;
  } in_item_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] pulse_width;
    logic                  last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic emit_mid;
    logic emit_last;
    logic emit_act;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_activate;
    logic same_route;
    logic div_done;
    logic mid_done;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== sv/srvramp_ctrl.sv =====
`timescale 1ns / 1ps

module srvramp_ctrl import srvramp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DISPATCH = 2'd1;
  localparam logic [1:0] ST_DIV      = 2'd2;
  localparam logic [1:0] ST_EMIT     = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.is_activate) begin
          if (status.slot_free) begin
            cmd.emit_act = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (status.same_route) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          if (!status.mid_done) begin
            cmd.emit_mid = 1'b1;
          end else begin
            cmd.emit_last = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/srvramp_dp.sv =====
`timescale 1ns / 1ps

module srvramp_dp import srvramp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  output out_item_t             out_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  logic [WIDTH_BITS-1:0] straight_r;
  logic [WIDTH_BITS-1:0] curved_r;
  logic [CNT_W-1:0]      steps_r;
  logic                  route_r;
  logic                  op_r;
  logic                  want_r;

  logic [WIDTH_BITS-1:0] end_r;
  logic [CNT_W-1:0]      count_r;
  logic                  neg_r;
  logic [CNT_W-1:0]      rem_r;
  logic [WIDTH_BITS-1:0] quo_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic [CNT_W-1:0]      idx_r;
  logic [WIDTH_BITS:0]   acc_r;

  out_item_t out_data_r;
  logic      out_valid_r;

  logic [WIDTH_BITS-1:0] ramp_start;
  logic [WIDTH_BITS-1:0] ramp_end;
  logic [WIDTH_BITS:0]   diff;
  logic [WIDTH_BITS:0]   diff_mag;
  logic [CNT_W-1:0]      eff_count;
  logic [CNT_W:0]        trial;
  logic                  fits;
  logic [WIDTH_BITS:0]   step;
  logic [WIDTH_BITS:0]   acc_sum;
  logic                  emit_any;

  // zero steps acts as one, anything past the maximum saturates
  always_comb begin
    if (steps_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (steps_r > CNT_W'(MAX_RAMP_STEPS)) begin
      eff_count = CNT_W'(MAX_RAMP_STEPS);
    end else begin
      eff_count = steps_r;
    end
  end

  assign ramp_start = (want_r == ROUTE_CURVED) ? straight_r : curved_r;
  assign ramp_end   = (want_r == ROUTE_CURVED) ? curved_r : straight_r;
  assign diff       = {1'b0, ramp_end} - {1'b0, ramp_start};
  assign diff_mag   = diff[WIDTH_BITS] ? (~diff + 1'b1) : diff;

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_r, quo_r[WIDTH_BITS-1]};
  assign fits  = (trial >= {1'b0, count_r});

  // sign-magnitude quotient truncates toward zero
  assign step    = neg_r ? (~{1'b0, quo_r} + 1'b1) : {1'b0, quo_r};
  assign acc_sum = acc_r + step;

  assign emit_any = cmd.emit_mid | cmd.emit_last | cmd.emit_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      straight_r <= '0;
      curved_r   <= '0;
      steps_r    <= RAMP_STEPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STRAIGHT_WIDTH: straight_r <= cfg_data[WIDTH_BITS-1:0];
        REG_CURVED_WIDTH:   curved_r   <= cfg_data[WIDTH_BITS-1:0];
        REG_RAMP_STEPS:     steps_r    <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_r <= ROUTE_STRAIGHT;
    end else if (cmd.emit_act) begin
      route_r <= ROUTE_STRAIGHT;
    end else if (cmd.emit_last) begin
      route_r <= want_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DCNT_W'(DIV_ITERS);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_data.operation;
      want_r <= in_data.desired_route;
    end
    if (cmd.div_start) begin
      end_r   <= ramp_end;
      count_r <= eff_count;
      neg_r   <= diff[WIDTH_BITS];
      rem_r   <= '0;
      quo_r   <= diff_mag[WIDTH_BITS-1:0];
      idx_r   <= CNT_W'(1);
      acc_r   <= {1'b0, ramp_start};
    end
    if (cmd.div_step) begin
      rem_r <= fits ? CNT_W'(trial - {1'b0, count_r}) : trial[CNT_W-1:0];
      quo_r <= {quo_r[WIDTH_BITS-2:0], fits};
    end
    if (cmd.emit_mid) begin
      acc_r <= acc_sum;
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mid) begin
      out_data_r.pulse_width <= acc_sum[WIDTH_BITS-1:0];
      out_data_r.last        <= 1'b0;
    end else if (cmd.emit_last) begin
      out_data_r.pulse_width <= end_r;
      out_data_r.last        <= 1'b1;
    end else if (cmd.emit_act) begin
      out_data_r.pulse_width <= straight_r;
      out_data_r.last        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_any) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_data  = out_data_r;
  assign out_valid = out_valid_r;

  assign status.is_activate = (op_r == OP_ACTIVATE);
  assign status.same_route  = (want_r == route_r);
  assign status.div_done    = (dcnt_r == '0);
  assign status.mid_done    = (idx_r == count_r);
  assign status.slot_free   = !out_valid_r || out_ready;

endmodule

// ===== sv/servo_position_ramp.sv =====
`timescale 1ns / 1ps

// two-position turnout servo driver. an activate request forces the straight
// route and returns the straight pulse width once, flagged last. a route
// request naming the stored route returns nothing; one naming the other route
// returns a linear ramp of N widths (N = ramp_steps, 0 read as 1, capped at
// 64) from the old route's width toward the new one, the final one being the
// exact end width flagged last. a request is taken only while the controller
// is idle, so requests are handled one at a time. an activate waits in
// dispatch until the output register is free; a route change goes through
// dispatch and setup, the bit-serial step divider (one quotient bit per cycle,
// one per width bit), a hand-over to the ramp, then emits its widths in order,
// holding while the output register is full. a same-route request passes
// through dispatch only. results sit in one output register, so a new
// request may be taken while the last result waits.
// configuration registers: 0 straight_width, 1 curved_width, 2 ramp_steps;
// writes to other indexes are dropped, and cfg_ready is always high.

module servo_position_ramp import srvramp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  // register writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // sequencer: dispatch, and for a route change divide, then walk the ramp
  srvramp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // config registers, route, divider, ramp accumulator, output register
  srvramp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== bench/servo_position_ramp_tb.sv =====
`timescale 1ns / 1ps

module servo_position_ramp_tb;
  import srvramp_pkg::*;

  // generous cycle ceiling, far above the slowest legal run
  localparam int CYCLE_LIMIT  = 1_000_000;
  // quiet time after the last result: covers dispatch, divider and a full ramp
  localparam int DRAIN_CYCLES = 100;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the block's registers and route
  logic [WIDTH_BITS-1:0] straight_w;
  logic [WIDTH_BITS-1:0] curved_w;
  logic [CNT_W-1:0]      steps_reg;
  logic                  route_now;

  // widths still owed by the block, oldest first
  out_item_t             pending_widths[$];
  out_item_t             owed;

  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    mismatch_count = 0;
  int                    cycle_count = 0;

  servo_position_ramp dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // run ceiling
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("servo_position_ramp: mismatch");
      $finish;
    end
  end

  // result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare every accepted result with the oldest owed width
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_widths.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing owed: expected none, actual width %0d last %0b",
                 $time, out_data.pulse_width, out_data.last);
      end else begin
        owed = pending_widths.pop_front();
        if (out_data.pulse_width !== owed.pulse_width) begin
          mismatch_count++;
          $display("%0t: pulse_width expected %0d actual %0d",
                   $time, owed.pulse_width, out_data.pulse_width);
        end
        if (out_data.last !== owed.last) begin
          mismatch_count++;
          $display("%0t: last expected %0b actual %0b", $time, owed.last, out_data.last);
        end
      end
    end
  end

  // work out the widths one accepted request owes and update the shadow route
  function automatic void predict_ramp(in_item_t req);
    int        first_w;
    int        end_w;
    int        delta;
    int        n;
    out_item_t item;
    if (req.operation == OP_ACTIVATE) begin
      // activate always lands on straight, one width flagged last
      route_now        = ROUTE_STRAIGHT;
      item.pulse_width = straight_w;
      item.last        = 1'b1;
      pending_widths.push_back(item);
      return;
    end
    // already there: nothing comes out
    if (req.desired_route == route_now) return;
    if (req.desired_route == ROUTE_CURVED) begin
      first_w = int'(straight_w);
      end_w   = int'(curved_w);
    end else begin
      first_w = int'(curved_w);
      end_w   = int'(straight_w);
    end
    // zero reads as one, anything past the cap saturates
    n = int'(steps_reg);
    if (n < 1) n = 1;
    if (n > MAX_RAMP_STEPS) n = MAX_RAMP_STEPS;
    // int division truncates toward zero, also on a falling ramp
    delta = (end_w - first_w) / n;
    for (int k = 1; k < n; k++) begin
      item.pulse_width = WIDTH_BITS'(first_w + k * delta);
      item.last        = 1'b0;
      pending_widths.push_back(item);
    end
    // the final width is exact, not start plus n steps
    item.pulse_width = WIDTH_BITS'(end_w);
    item.last        = 1'b1;
    pending_widths.push_back(item);
    route_now = req.desired_route;
  endfunction

  // present one request, with random idle cycles ahead of it
  task automatic send_request(logic op, logic route);
    in_item_t req;
    req.operation     = op;
    req.desired_route = route;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_ramp(req);
  endtask

  // one register write; only called while the block is quiet
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STRAIGHT_WIDTH: straight_w = data[WIDTH_BITS-1:0];
      REG_CURVED_WIDTH:   curved_w   = data[WIDTH_BITS-1:0];
      REG_RAMP_STEPS:     steps_reg  = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every owed width, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_widths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // width pick biased toward the ends of the range
  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CFG_DATA_W'($urandom);
  endfunction

  // registers at reset: both widths 0, ten steps, straight route
  task automatic test_reset_values();
    send_request(OP_ACTIVATE, ROUTE_CURVED);
    send_request(OP_ROUTE, ROUTE_STRAIGHT);
    send_request(OP_ROUTE, ROUTE_CURVED);
    send_request(OP_ROUTE, ROUTE_CURVED);
  endtask

  // widest swing with the longest ramp, both directions
  task automatic test_full_scale();
    settle();
    write_reg(REG_STRAIGHT_WIDTH, 12'd0);
    write_reg(REG_CURVED_WIDTH, 12'hFFF);
    write_reg(REG_RAMP_STEPS, 12'd64);
    send_request(OP_ROUTE, ROUTE_STRAIGHT);
    send_request(OP_ROUTE, ROUTE_CURVED);
    send_request(OP_ROUTE, ROUTE_STRAIGHT);
    send_request(OP_ACTIVATE, ROUTE_STRAIGHT);
  endtask

  // zero, single, uneven, saturating step counts
  task automatic test_ramp_lengths();
    settle();
    write_reg(REG_STRAIGHT_WIDTH, 12'd100);
    write_reg(REG_CURVED_WIDTH, 12'd3000);
    write_reg(REG_RAMP_STEPS, 12'd0);
    send_request(OP_ROUTE, ROUTE_CURVED);
    settle();
    write_reg(REG_RAMP_STEPS, 12'd1);
    send_request(OP_ROUTE, ROUTE_STRAIGHT);
    settle();
    // uneven difference: truncation shows on the falling ramp
    write_reg(REG_RAMP_STEPS, 12'd7);
    send_request(OP_ROUTE, ROUTE_CURVED);
    send_request(OP_ROUTE, ROUTE_STRAIGHT);
    settle();
    // upper data bits dropped, 127 caps at the maximum
    write_reg(REG_RAMP_STEPS, 12'hFFF);
    send_request(OP_ROUTE, ROUTE_CURVED);
    settle();
    write_reg(REG_RAMP_STEPS, 12'd65);
    send_request(OP_ROUTE, ROUTE_STRAIGHT);
  endtask

  // writes to the spare index must leave every register alone
  task automatic test_unknown_index();
    settle();
    write_reg(REG_SPARE, 12'hFFF);
    write_reg(REG_SPARE, 12'h000);
    send_request(OP_ACTIVATE, ROUTE_STRAIGHT);
    send_request(OP_ROUTE, ROUTE_CURVED);
  endtask

  // activate pulls the route back even while curved; equal widths give flat ramps
  task automatic test_activate_and_flat();
    send_request(OP_ACTIVATE, ROUTE_CURVED);
    send_request(OP_ROUTE, ROUTE_CURVED);
    send_request(OP_ACTIVATE, ROUTE_STRAIGHT);
    send_request(OP_ROUTE, ROUTE_STRAIGHT);
    settle();
    write_reg(REG_CURVED_WIDTH, 12'd100);
    write_reg(REG_RAMP_STEPS, 12'd5);
    send_request(OP_ROUTE, ROUTE_CURVED);
  endtask

  // random requests in blocks, a fresh register set before each block
  task automatic test_random_traffic(int snd_pct, int rcv_pct, int n_items);
    logic [CFG_DATA_W-1:0] steps_word;
    int                    r;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int blk = 0; blk < 5; blk++) begin
      settle();
      write_reg(REG_STRAIGHT_WIDTH, pick_width());
      write_reg(REG_CURVED_WIDTH, pick_width());
      // mostly short ramps, now and then zero, the cap or past it
      steps_word = CFG_DATA_W'($urandom);
      r = $urandom_range(99);
      if (r < 5) steps_word[CNT_W-1:0] = '0;
      else if (r < 10) steps_word[CNT_W-1:0] = CNT_W'(MAX_RAMP_STEPS);
      else if (r < 15) steps_word[CNT_W-1:0] = CNT_W'($urandom_range(127, MAX_RAMP_STEPS + 1));
      else steps_word[CNT_W-1:0] = CNT_W'($urandom_range(12, 1));
      write_reg(REG_RAMP_STEPS, steps_word);
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      for (int k = 0; k < n_items / 5; k++) begin
        if ($urandom_range(99) < 25) send_request(OP_ACTIVATE, 1'($urandom_range(1)));
        else send_request(OP_ROUTE, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 19;
    recv_idle_pct  = 45;
    straight_w     = '0;
    curved_w       = '0;
    steps_reg      = RAMP_STEPS_RESET;
    route_now      = ROUTE_STRAIGHT;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_full_scale();
    test_ramp_lengths();
    test_unknown_index();
    test_activate_and_flat();

    test_random_traffic(19, 45, 155);
    test_random_traffic(45, 19, 155);
    test_random_traffic(0, 0, 160);

    settle();
    if (mismatch_count == 0 && pending_widths.size() == 0) begin
      $display("servo_position_ramp: match");
    end else begin
      $display("servo_position_ramp: mismatch");
    end
    $finish;
  end

endmodule
